// ===== hdl/dstq_pkg.sv =====
// Package for the deadline-sorted timer queue.
// Holds the item structs, queue entry type, cell control and status codes.
// No dependencies; used by the cell, the top level and the checker.
`default_nettype none

package dstq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  localparam logic [31:0] CPS_RESET  = 32'd19200000;
  localparam logic        ACT_ADD    = 1'b0;
  localparam logic        ACT_EXPIRE = 1'b1;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    OP_HOLD  = 2'd0,
    OP_NEW   = 2'd1,
    OP_LEFT  = 2'd2,
    OP_RIGHT = 2'd3
  } cell_op_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_CALC = 2'd1,
    S_MUL  = 2'd2,
    S_OUT  = 2'd3
  } state_t;

  typedef struct packed {
    logic        action;
    logic [31:0] now_seconds;
    logic [30:0] delay_seconds;
    logic [7:0]  timer_tag;
  } in_item_t;

  typedef struct packed {
    status_t     status;
    logic        reload_valid;
    logic [63:0] reload_count;
    logic [7:0]  due_tag;
    logic [31:0] due_set_time;
    logic [31:0] due_now_time;
    logic        queue_empty;
  } out_item_t;

  typedef struct packed {
    logic [32:0] deadline;
    logic [7:0]  tag;
    logic [31:0] set_time;
  } entry_t;

  typedef struct packed {
    cell_op_t op;
    logic     occ;
  } cell_ctrl_t;

endpackage

`default_nettype wire

// ===== hdl/dstq_cell.sv =====
// One cell of the sorted queue chain: holds one entry.
// Compares its deadline with the incoming one and loads from new, left or right.
// Depends on dstq_pkg.
`default_nettype none

module dstq_cell (
  input  wire logic               clk,
  input  wire dstq_pkg::cell_ctrl_t ctrl,
  input  wire dstq_pkg::entry_t   new_entry,
  input  wire dstq_pkg::entry_t   left_entry,
  input  wire dstq_pkg::entry_t   right_entry,
  output dstq_pkg::entry_t        entry,
  output logic                    le
);

  dstq_pkg::entry_t entry_r;

  // equal deadlines count as earlier so ties keep arrival order
  assign le    = ctrl.occ && (entry_r.deadline <= new_entry.deadline);
  assign entry = entry_r;

  always_ff @(posedge clk) begin
    case (ctrl.op)
      dstq_pkg::OP_HOLD:  entry_r <= entry_r;
      dstq_pkg::OP_NEW:   entry_r <= new_entry;
      dstq_pkg::OP_LEFT:  entry_r <= left_entry;
      dstq_pkg::OP_RIGHT: entry_r <= right_entry;
      default:            entry_r <= entry_r;
    endcase
  end

endmodule

`default_nettype wire

// ===== hdl/dstq_reload.sv =====
// Reload count unit: remaining seconds of the front entry times counts per second.
// Two register stages (clamped subtract, then 32x33 multiply), saturating output.
// No package dependency; all ports are plain vectors.
`default_nettype none

module dstq_reload (
  input  wire logic        clk,
  input  wire logic [32:0] front_deadline,
  input  wire logic [31:0] now_sec,
  input  wire logic [31:0] cps,
  output logic [63:0]      reload_count
);

  logic [32:0] rem_r;
  logic [32:0] rem_nxt;
  logic [64:0] prod_r;
  logic [64:0] prod_nxt;

  always_comb begin
    // clamp a deadline that has already passed to zero
    if (front_deadline > {1'b0, now_sec}) begin
      rem_nxt = front_deadline - {1'b0, now_sec};
    end else begin
      rem_nxt = '0;
    end
    prod_nxt = {33'd0, cps} * {32'd0, rem_r};
  end

  always_ff @(posedge clk) begin
    rem_r  <= rem_nxt;
    prod_r <= prod_nxt;
  end

  assign reload_count = prod_r[64] ? {64{1'b1}} : prod_r[63:0];

endmodule

`default_nettype wire

// ===== hdl/deadline_sorted_timer_queue_top.sv =====
// Deadline-sorted timer queue: top level with control FSM, cell chain and reload unit.
// Depends on dstq_pkg, dstq_cell and dstq_reload.
//
// Keeps up to QUEUE_DEPTH one-shot timers sorted by absolute deadline in a row
// of cells; an add files its entry and an expire pops the front, both in the
// single cycle the item is accepted, by every cell comparing against the new
// deadline and shifting with its neighbor. Each item then yields one result
// through these steps in order: the cells update at the accepting edge, then
// come the clamped subtract of the front deadline, the 32x33 multiply for the
// reload count, and the load of the output register, which waits while the
// output side stalls. One item is in work at a time, so no new item is taken
// until its result is loaded; a new item is taken while the previous result
// still waits in the output register. No clearing pass after reset.
`default_nettype none

module deadline_sorted_timer_queue_top (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire dstq_pkg::in_item_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output dstq_pkg::out_item_t      out_data,
  input  wire logic                cfg_we,
  input  wire logic [31:0]         cfg_data
);

  localparam int QD = dstq_pkg::QUEUE_DEPTH;
  localparam int CW = dstq_pkg::CNT_W;

  dstq_pkg::state_t    state_r, state_nxt;
  logic [CW-1:0]       count_r, count_nxt;
  logic [31:0]         cps_r;
  logic [31:0]         now_r;
  dstq_pkg::status_t   status_r;
  logic                rvalid_r;
  logic [7:0]          dtag_r;
  logic [31:0]         dset_r;
  logic [31:0]         dnow_r;
  logic                empty_r;
  logic                out_valid_r;
  dstq_pkg::out_item_t out_data_r;

  dstq_pkg::entry_t     new_entry;
  dstq_pkg::entry_t     cell_q   [QD];
  dstq_pkg::entry_t     left_in  [QD];
  dstq_pkg::entry_t     right_in [QD];
  dstq_pkg::cell_ctrl_t ctrl     [QD];
  logic [QD-1:0]        le;
  logic [QD-1:0]        le_prev;

  logic        acc, is_add, full, empty, add_ok, pop_ok, load_out;
  logic [63:0] reload_count;

  assign acc    = in_valid && in_ready;
  assign is_add = (in_data.action == dstq_pkg::ACT_ADD);
  assign full   = (count_r == CW'(QD));
  assign empty  = (count_r == '0);
  assign add_ok = acc && is_add && !full;
  assign pop_ok = acc && (in_data.action == dstq_pkg::ACT_EXPIRE) && !empty;

  assign new_entry.deadline = {1'b0, in_data.now_seconds} + {2'b00, in_data.delay_seconds};
  assign new_entry.tag      = in_data.timer_tag;
  assign new_entry.set_time = in_data.now_seconds;

  assign le_prev = {le[QD-2:0], 1'b1};

  always_comb begin
    for (int i = 0; i < QD; i++) begin
      ctrl[i].occ = (CW'(i) < count_r);
      if (add_ok) begin
        if (le[i]) begin
          ctrl[i].op = dstq_pkg::OP_HOLD;
        end else if (le_prev[i]) begin
          ctrl[i].op = dstq_pkg::OP_NEW;
        end else begin
          ctrl[i].op = dstq_pkg::OP_LEFT;
        end
      end else if (pop_ok) begin
        ctrl[i].op = dstq_pkg::OP_RIGHT;
      end else begin
        ctrl[i].op = dstq_pkg::OP_HOLD;
      end
    end
  end

  for (genvar g = 0; g < QD; g++) begin : g_cell
    if (g == 0) begin : g_first
      assign left_in[g] = new_entry;
    end else begin : g_mid
      assign left_in[g] = cell_q[g-1];
    end
    if (g == QD - 1) begin : g_last
      assign right_in[g] = cell_q[g];
    end else begin : g_inner
      assign right_in[g] = cell_q[g+1];
    end
    dstq_cell u_cell (
      .clk         (clk),
      .ctrl        (ctrl[g]),
      .new_entry   (new_entry),
      .left_entry  (left_in[g]),
      .right_entry (right_in[g]),
      .entry       (cell_q[g]),
      .le          (le[g])
    );
  end

  dstq_reload u_reload (
    .clk            (clk),
    .front_deadline (cell_q[0].deadline),
    .now_sec        (now_r),
    .cps            (cps_r),
    .reload_count   (reload_count)
  );

  always_comb begin
    count_nxt = count_r;
    if (add_ok) begin
      count_nxt = count_r + CW'(1);
    end else if (pop_ok) begin
      count_nxt = count_r - CW'(1);
    end
  end

  assign load_out = (state_r == dstq_pkg::S_OUT) && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    case (state_r)
      dstq_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_nxt = dstq_pkg::S_CALC;
        end
      end
      dstq_pkg::S_CALC: state_nxt = dstq_pkg::S_MUL;
      dstq_pkg::S_MUL:  state_nxt = dstq_pkg::S_OUT;
      dstq_pkg::S_OUT: begin
        // hold until the output register is free
        if (load_out) begin
          state_nxt = dstq_pkg::S_IDLE;
        end
      end
      default: state_nxt = dstq_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= dstq_pkg::S_IDLE;
      count_r     <= '0;
      cps_r       <= dstq_pkg::CPS_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      if (cfg_we) begin
        cps_r <= cfg_data;
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // per-item result fields, captured at acceptance
  always_ff @(posedge clk) begin
    if (acc) begin
      now_r <= in_data.now_seconds;
      if (is_add) begin
        status_r <= full ? dstq_pkg::ST_FULL : dstq_pkg::ST_OK;
      end else begin
        status_r <= empty ? dstq_pkg::ST_EMPTY : dstq_pkg::ST_OK;
      end
      rvalid_r <= (add_ok && !le[0]) || (pop_ok && (count_r != CW'(1)));
      dtag_r   <= pop_ok ? cell_q[0].tag : 8'd0;
      dset_r   <= pop_ok ? cell_q[0].set_time : 32'd0;
      dnow_r   <= pop_ok ? in_data.now_seconds : 32'd0;
      empty_r  <= (count_nxt == '0);
    end
    if (load_out) begin
      out_data_r.status       <= status_r;
      out_data_r.reload_valid <= rvalid_r;
      out_data_r.reload_count <= rvalid_r ? reload_count : 64'd0;
      out_data_r.due_tag      <= dtag_r;
      out_data_r.due_set_time <= dset_r;
      out_data_r.due_now_time <= dnow_r;
      out_data_r.queue_empty  <= empty_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

// ===== hdl/dstq_checker.sv =====
// Port-level checker for the deadline-sorted timer queue, bound to the top level.
// Depends on dstq_pkg and deadline_sorted_timer_queue_top.
`default_nettype none

module dstq_checker (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                in_valid,
  input wire logic                in_ready,
  input wire logic                out_valid,
  input wire logic                out_ready,
  input wire dstq_pkg::out_item_t out_data
);

  // a held result must not change
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result item changed while stalled");

  // one item in work at a time
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second item accepted while one is in work");

  a_full_no_reload: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == dstq_pkg::ST_FULL)
      |-> !out_data.reload_valid && !out_data.queue_empty)
    else $error("dropped add reported reload or empty queue");

  a_empty_pop: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == dstq_pkg::ST_EMPTY)
      |-> out_data.queue_empty && !out_data.reload_valid && (out_data.due_tag == 8'd0))
    else $error("expire on empty queue reported wrong fields");

  a_reload_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.reload_valid |-> !out_data.queue_empty)
    else $error("reload requested for an empty queue");

endmodule

bind deadline_sorted_timer_queue_top dstq_checker u_dstq_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire
